[rtl/tpsf_pkg.sv]
// Shared widths, codes and types for the two-point spring force core.
`default_nettype none

package tpsf_pkg;

    // Field and datapath widths.
    localparam int POS_W   = 32;              // Q16.16 position and force
    localparam int MAG_W   = POS_W + 1;       // magnitude of one offset component
    localparam int SQ_W    = 2 * MAG_W;       // square of one component
    localparam int RAD_W   = SQ_W + 2;        // sum of three squares, even width
    localparam int ROOT_W  = RAD_W / 2;       // spring length
    localparam int REM_W   = ROOT_W + 2;      // square root remainder
    localparam int CFG_W   = 31;              // widest register
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W  = 64;              // stiffness times offset magnitude
    localparam int EXT_W   = ROOT_W + 1;      // signed extension
    localparam int EXTM_W  = ROOT_W;          // extension magnitude
    localparam int HALF_W  = PROD_W / 2;      // partial product split
    localparam int PP_W    = HALF_W + EXTM_W; // one partial product
    localparam int NUM_W   = 97;              // full numerator
    localparam int FRAC_W  = 16;
    localparam int DEN_W   = ROOT_W + FRAC_W; // length scaled by 2^16
    localparam int QUO_W   = 32;              // quotient bits computed

    // Pipeline depths.
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;

    // Register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_STIFFNESS = 2'd0;
    localparam t_cfg_idx CFG_REST_LEN  = 2'd1;
    localparam t_cfg_idx CFG_BUNGEE    = 2'd2;

    localparam logic [CFG_W-1:0] STIFFNESS_RST = 31'd65536;
    localparam logic [CFG_W-1:0] REST_LEN_RST  = 31'd65536;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_APPLIED = 2'd0;
    localparam t_status ST_SLACK   = 2'd1;
    localparam t_status ST_ZERO    = 2'd2;
    localparam t_status ST_SAT     = 2'd3;

    // Offset magnitudes and signs that ride along with the root.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            dneg;
    } t_axis_side;

    // Per-word flags that ride along with the dividers.
    typedef struct packed {
        logic       slack;
        logic       zero;
        logic [2:0] fneg;
        logic [2:0] big;
    } t_flags;

endpackage

`default_nettype wire

[rtl/two_point_spring_force_core.sv]
// Two-point spring force core: offset, length, Hooke force and saturation.
//
// Input channel: i_valid / o_stall carry one word with the particle and
// partner positions (signed Q16.16). Output channel: o_valid / i_stall
// carry one word with the three force components and a status code.
// A word moves at a rising edge where valid is high and stall is low.
// One result word is produced for each input word, in order.
// Throughput is one word per cycle when the receiver does not stall. The
// pipeline from accept to o_valid has three stages for offset, squares
// and sum, 34 square root stages, four stages for slack test, products
// and the overflow compare, 32 divider stages and the output register.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and o_stall rises; nothing is dropped or repeated. Bubbles in the
// pipeline advance as long as the output register is empty or drained.
// The configuration port writes stiffness, rest length and bungee mode;
// write it only while no word is in flight.
// Synchronous reset empties the pipeline and restores stiffness and rest
// length to 1.0 with bungee mode off.
`default_nettype none

module two_point_spring_force_core
    import tpsf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic signed [POS_W-1:0] i_self_x,
    input  wire logic signed [POS_W-1:0] i_self_y,
    input  wire logic signed [POS_W-1:0] i_self_z,
    input  wire logic signed [POS_W-1:0] i_partner_x,
    input  wire logic signed [POS_W-1:0] i_partner_y,
    input  wire logic signed [POS_W-1:0] i_partner_z,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [POS_W-1:0]    o_force_x,
    output logic signed [POS_W-1:0]    o_force_y,
    output logic signed [POS_W-1:0]    o_force_z,
    output logic [1:0]                 o_status
);

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic en;

    // Configuration registers.
    logic [CFG_W-1:0] r_stiffness;
    logic [CFG_W-1:0] r_rest_len;
    logic             r_bungee;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= STIFFNESS_RST;
            r_rest_len  <= REST_LEN_RST;
            r_bungee    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STIFFNESS: r_stiffness <= i_cfg_data;
                CFG_REST_LEN:  r_rest_len  <= i_cfg_data;
                CFG_BUNGEE:    r_bungee    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Global advance: everything moves unless a finished word is held.
    logic r_o_v;
    assign en      = !r_o_v || !i_stall;
    assign o_stall = !en;

    // Stage 1: offset components and their magnitudes.
    logic [2:0][POS_W-1:0] w_self;
    logic [2:0][POS_W-1:0] w_part;
    logic                  r_s1_v;
    t_axis_side            r_s1_side;
    t_axis_side            n_s1_side;

    assign w_self = {i_self_z, i_self_y, i_self_x};
    assign w_part = {i_partner_z, i_partner_y, i_partner_x};

    always_comb begin
        logic [MAG_W-1:0] diff;
        for (int a = 0; a < 3; a++) begin
            diff = {w_self[a][POS_W-1], w_self[a]} - {w_part[a][POS_W-1], w_part[a]};
            n_s1_side.dneg[a] = diff[MAG_W-1];
            n_s1_side.mag[a]  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
        end
    end

    // Stage 2: squares.
    logic                  r_s2_v;
    t_axis_side            r_s2_side;
    logic [2:0][SQ_W-1:0]  r_s2_sq;

    // Stage 3: sum of squares.
    logic                  r_s3_v;
    t_axis_side            r_s3_side;
    logic [RAD_W-1:0]      r_s3_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= n_s1_side;
            r_s2_side <= r_s1_side;
            for (int a = 0; a < 3; a++) begin
                r_s2_sq[a] <= SQ_W'(r_s1_side.mag[a]) * SQ_W'(r_s1_side.mag[a]);
            end
            r_s3_side <= r_s2_side;
            r_s3_rad  <= RAD_W'(r_s2_sq[0]) + RAD_W'(r_s2_sq[1]) + RAD_W'(r_s2_sq[2]);
        end
    end

    // Spring length.
    logic              w_sq_v;
    logic [ROOT_W-1:0] w_root;
    t_axis_side        w_sq_side;

    tpsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_rad   (r_s3_rad),
        .i_side  (r_s3_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Stage 4: slack and zero tests, extension, stiffness products.
    logic [EXT_W-1:0]  w_ext;
    logic              w_ext_neg;
    logic              w_ext_pos;
    logic [2:0]        n_s4_fneg;

    assign w_ext     = EXT_W'(w_root) - EXT_W'(r_rest_len);
    assign w_ext_neg = w_ext[EXT_W-1];
    assign w_ext_pos = !w_ext[EXT_W-1] && (w_ext != '0);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_s4_fneg[a] = (w_ext_pos && !w_sq_side.dneg[a] && (w_sq_side.mag[a] != '0)) ||
                           (w_ext_neg && w_sq_side.dneg[a]);
        end
    end

    logic                    r_s4_v;
    logic                    r_s4_slack;
    logic                    r_s4_zero;
    logic [2:0]              r_s4_fneg;
    logic [EXTM_W-1:0]       r_s4_extm;
    logic [DEN_W-1:0]        r_s4_den;
    logic [2:0][PROD_W-1:0]  r_s4_prod;

    // Stage 5: partial products of the wide multiply.
    logic                    r_s5_v;
    logic                    r_s5_slack;
    logic                    r_s5_zero;
    logic [2:0]              r_s5_fneg;
    logic [DEN_W-1:0]        r_s5_den;
    logic [2:0][PP_W-1:0]    r_s5_plo;
    logic [2:0][PP_W-1:0]    r_s5_phi;

    // Stage 6: full numerator.
    logic                    r_s6_v;
    logic                    r_s6_slack;
    logic                    r_s6_zero;
    logic [2:0]              r_s6_fneg;
    logic [DEN_W-1:0]        r_s6_den;
    logic [2:0][NUM_W-1:0]   r_s6_num;

    // Stage 7: quotient overflow test and divider setup.
    logic                    r_s7_v;
    t_flags                  r_s7_flags;
    logic [DEN_W-1:0]        r_s7_den;
    logic [2:0][DEN_W-1:0]   r_s7_rem;
    logic [2:0][QUO_W-1:0]   r_s7_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= w_sq_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_slack <= r_bungee && (w_root < ROOT_W'(r_rest_len));
            r_s4_zero  <= (w_root == '0);
            r_s4_fneg  <= n_s4_fneg;
            r_s4_extm  <= w_ext_neg ? EXTM_W'(~w_ext + EXT_W'(1)) : w_ext[EXTM_W-1:0];
            r_s4_den   <= {w_root, {FRAC_W{1'b0}}};
            for (int a = 0; a < 3; a++) begin
                r_s4_prod[a] <= PROD_W'(r_stiffness) * PROD_W'(w_sq_side.mag[a]);
            end

            r_s5_slack <= r_s4_slack;
            r_s5_zero  <= r_s4_zero;
            r_s5_fneg  <= r_s4_fneg;
            r_s5_den   <= r_s4_den;
            for (int a = 0; a < 3; a++) begin
                r_s5_plo[a] <= PP_W'(r_s4_prod[a][HALF_W-1:0]) * PP_W'(r_s4_extm);
                r_s5_phi[a] <= PP_W'(r_s4_prod[a][PROD_W-1:HALF_W]) * PP_W'(r_s4_extm);
            end

            r_s6_slack <= r_s5_slack;
            r_s6_zero  <= r_s5_zero;
            r_s6_fneg  <= r_s5_fneg;
            r_s6_den   <= r_s5_den;
            for (int a = 0; a < 3; a++) begin
                r_s6_num[a] <= NUM_W'(r_s5_plo[a]) + (NUM_W'(r_s5_phi[a]) << HALF_W);
            end

            // A numerator at or above den * 2^32 means the quotient saturates.
            r_s7_flags.slack <= r_s6_slack;
            r_s7_flags.zero  <= r_s6_zero;
            r_s7_flags.fneg  <= r_s6_fneg;
            r_s7_den         <= r_s6_den;
            for (int a = 0; a < 3; a++) begin
                r_s7_flags.big[a] <= r_s6_num[a][NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(r_s6_den);
                r_s7_rem[a]       <= r_s6_num[a][QUO_W+DEN_W-1:QUO_W];
                r_s7_low[a]       <= r_s6_num[a][QUO_W-1:0];
            end
        end
    end

    // Dividers, one per axis, with the flags delayed alongside.
    logic [2:0][QUO_W-1:0] w_quo;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_axis
            tpsf_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (r_s7_rem[g]),
                .i_low (r_s7_low[g]),
                .i_den (r_s7_den),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    logic   r_dl_v     [DIV_STEPS];
    t_flags r_dl_flags [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dl_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_dl_v[0] <= r_s7_v;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dl_v[k] <= r_dl_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_flags[0] <= r_s7_flags;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dl_flags[k] <= r_dl_flags[k-1];
            end
        end
    end

    // Final stage: sign, saturation and status.
    t_flags                w_fl;
    logic [2:0][POS_W-1:0] n_force;
    logic [2:0]            w_sat;
    t_status               n_status;

    assign w_fl = r_dl_flags[DIV_STEPS-1];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (w_fl.fneg[a]) begin
                w_sat[a]   = w_fl.big[a] || (w_quo[a] > POS_MIN);
                n_force[a] = w_sat[a] ? POS_MIN : (~w_quo[a] + POS_W'(1));
            end else begin
                w_sat[a]   = w_fl.big[a] || (w_quo[a] > POS_MAX);
                n_force[a] = w_sat[a] ? POS_MAX : w_quo[a];
            end
        end
        if (w_fl.slack) begin
            n_status = ST_SLACK;
            n_force  = '0;
        end else if (w_fl.zero) begin
            n_status = ST_ZERO;
            n_force  = '0;
        end else if (w_sat != 3'b000) begin
            n_status = ST_SAT;
        end else begin
            n_status = ST_APPLIED;
        end
    end

    // Output register.
    logic [POS_W-1:0] r_o_fx;
    logic [POS_W-1:0] r_o_fy;
    logic [POS_W-1:0] r_o_fz;
    t_status          r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_dl_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_fx     <= n_force[0];
            r_o_fy     <= n_force[1];
            r_o_fz     <= n_force[2];
            r_o_status <= n_status;
        end
    end

    assign o_valid   = r_o_v;
    assign o_force_x = r_o_fx;
    assign o_force_y = r_o_fy;
    assign o_force_z = r_o_fz;
    assign o_status  = r_o_status;

    // The input side only stalls behind a held result word.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result word");

    // Slack and zero-length words carry no force.
    a_no_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SLACK || o_status == ST_ZERO)) |->
        (o_force_x == '0 && o_force_y == '0 && o_force_z == '0))
        else $error("slack or zero-length word with nonzero force");

    // A saturated word has at least one component at a bound.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SAT) |->
        (r_o_fx == POS_MAX || r_o_fx == POS_MIN || r_o_fy == POS_MAX ||
         r_o_fy == POS_MIN || r_o_fz == POS_MAX || r_o_fz == POS_MIN))
        else $error("saturated status without a clamped component");

endmodule

`default_nettype wire

[rtl/tpsf_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none

module tpsf_sqrt
    import tpsf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [RAD_W-1:0]  i_rad,
    input  wire t_axis_side        i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output t_axis_side             o_side
);

    logic                r_v    [SQRT_STEPS];
    logic [RAD_W-1:0]    r_rad  [SQRT_STEPS];
    logic [REM_W-1:0]    r_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0]   r_root [SQRT_STEPS];
    t_axis_side          r_side [SQRT_STEPS];
    logic [RAD_W-1:0]    n_rad  [SQRT_STEPS];
    logic [REM_W-1:0]    n_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0]   n_root [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++) begin : g_step
            logic              w_v;
            logic [RAD_W-1:0]  w_rad;
            logic [REM_W-1:0]  w_rem;
            logic [ROOT_W-1:0] w_root;
            t_axis_side        w_side;
            logic [REM_W+1:0]  w_try;
            logic [REM_W+1:0]  w_trial;

            // Stage input comes from the port or from the previous stage.
            if (k == 0) begin : g_first
                assign w_v    = i_valid;
                assign w_rad  = i_rad;
                assign w_rem  = '0;
                assign w_root = '0;
                assign w_side = i_side;
            end else begin : g_next
                assign w_v    = r_v[k-1];
                assign w_rad  = r_rad[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_root = r_root[k-1];
                assign w_side = r_side[k-1];
            end

            // Bring down two radicand bits and try the next root bit.
            always_comb begin
                w_try   = {w_rem, w_rad[RAD_W-1 -: 2]};
                w_trial = {2'b00, w_root, 2'b01};
                if (w_try >= w_trial) begin
                    n_rem[k]  = REM_W'(w_try - w_trial);
                    n_root[k] = {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem[k]  = w_try[REM_W-1:0];
                    n_root[k] = {w_root[ROOT_W-2:0], 1'b0};
                end
                n_rad[k] = {w_rad[RAD_W-3:0], 2'b00};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= w_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k]  <= n_rad[k];
                    r_rem[k]  <= n_rem[k];
                    r_root[k] <= n_root[k];
                    r_side[k] <= w_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

`default_nettype wire

[rtl/tpsf_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module tpsf_div
    import tpsf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DEN_W-1:0]  i_rem,
    input  wire logic [QUO_W-1:0]  i_low,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic [QUO_W-1:0]       o_quo
);

    logic [DEN_W-1:0] r_rem [DIV_STEPS];
    logic [QUO_W-1:0] r_low [DIV_STEPS];
    logic [DEN_W-1:0] r_den [DIV_STEPS];
    logic [QUO_W-1:0] r_quo [DIV_STEPS];
    logic [DEN_W-1:0] n_rem [DIV_STEPS];
    logic [QUO_W-1:0] n_quo [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [DEN_W-1:0] w_rem;
            logic [QUO_W-1:0] w_low;
            logic [DEN_W-1:0] w_den;
            logic [QUO_W-1:0] w_quo;
            logic [DEN_W:0]   w_try;

            if (k == 0) begin : g_first
                assign w_rem = i_rem;
                assign w_low = i_low;
                assign w_den = i_den;
                assign w_quo = '0;
            end else begin : g_next
                assign w_rem = r_rem[k-1];
                assign w_low = r_low[k-1];
                assign w_den = r_den[k-1];
                assign w_quo = r_quo[k-1];
            end

            // Shift in the next numerator bit and subtract when it fits.
            always_comb begin
                w_try = {w_rem, w_low[QUO_W-1]};
                if (w_try >= {1'b0, w_den}) begin
                    n_rem[k] = DEN_W'(w_try - {1'b0, w_den});
                    n_quo[k] = {w_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[k] = w_try[DEN_W-1:0];
                    n_quo[k] = {w_quo[QUO_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem[k];
                    r_low[k] <= {w_low[QUO_W-2:0], 1'b0};
                    r_den[k] <= w_den;
                    r_quo[k] <= n_quo[k];
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

`default_nettype wire
